FILE: design/evm_alu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_alu_pkg
// Shared types and operation codes of the 256-bit stack-machine ALU.
// ----------------------------------------------------------------------------
package evm_alu_pkg;

  localparam int unsigned WordBits = 256;
  localparam int unsigned LimbBits = 64;
  localparam int unsigned ModeBits = 5;

  typedef logic [ModeBits-1:0] alu_mode_t;

  localparam alu_mode_t MODE_ADD        = 5'd0;
  localparam alu_mode_t MODE_SUB        = 5'd1;
  localparam alu_mode_t MODE_LT         = 5'd2;
  localparam alu_mode_t MODE_GT         = 5'd3;
  localparam alu_mode_t MODE_SLT        = 5'd4;
  localparam alu_mode_t MODE_SGT        = 5'd5;
  localparam alu_mode_t MODE_EQ         = 5'd6;
  localparam alu_mode_t MODE_ISZERO     = 5'd7;
  localparam alu_mode_t MODE_AND        = 5'd8;
  localparam alu_mode_t MODE_OR         = 5'd9;
  localparam alu_mode_t MODE_XOR        = 5'd10;
  localparam alu_mode_t MODE_NOT        = 5'd11;
  localparam alu_mode_t MODE_BYTE       = 5'd12;
  localparam alu_mode_t MODE_SHL        = 5'd13;
  localparam alu_mode_t MODE_SHR        = 5'd14;
  localparam alu_mode_t MODE_SAR        = 5'd15;
  localparam alu_mode_t MODE_SIGNEXTEND = 5'd16;

  typedef struct packed {
    alu_mode_t           mode;
    logic [LimbBits-1:0] first_w0;
    logic [LimbBits-1:0] first_w1;
    logic [LimbBits-1:0] first_w2;
    logic [LimbBits-1:0] first_w3;
    logic [LimbBits-1:0] second_w0;
    logic [LimbBits-1:0] second_w1;
    logic [LimbBits-1:0] second_w2;
    logic [LimbBits-1:0] second_w3;
  } alu_cmd_t;

  typedef struct packed {
    logic [LimbBits-1:0] result_w0;
    logic [LimbBits-1:0] result_w1;
    logic [LimbBits-1:0] result_w2;
    logic [LimbBits-1:0] result_w3;
  } alu_result_t;

  // operations whose result is a single 0/1 flag
  function automatic logic is_flag_mode(input alu_mode_t mode);
    return (mode == MODE_LT) || (mode == MODE_GT) || (mode == MODE_SLT) ||
           (mode == MODE_SGT) || (mode == MODE_EQ) || (mode == MODE_ISZERO);
  endfunction

endpackage

FILE: design/evm_word_alu_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_word_alu_core
// 256-bit stack-machine ALU: one operation per command, one result per
// command, input register -> datapath -> result register.
// ----------------------------------------------------------------------------
//   channel   ports              transfer
//   command   start, busy, cmd   start && !busy at rising edge
//   result    done, result       done high for one cycle, always taken
//
// A command accepted at a rising edge is held in in_valid / in_cmd, then its
// result is loaded into the result register together with done.
// busy never rises: one command per cycle, sustained, limited only by the
// single pass through the 256-bit adder / barrel shifter in evm_alu_exec.
// Synchronous reset drops any command in flight; no result follows it.
// The receiver cannot stall, so results never wait.
// ----------------------------------------------------------------------------
module evm_word_alu_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  evm_alu_pkg::alu_cmd_t    cmd,
  output logic                     done,
  output evm_alu_pkg::alu_result_t result
);
  import evm_alu_pkg::*;

  logic        in_valid;
  alu_cmd_t    in_cmd;
  alu_result_t exec_result;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start && !busy;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_cmd <= cmd;
    end
    if (in_valid) begin
      result <= exec_result;
    end
  end

  evm_alu_exec u_exec (
    .cmd    (in_cmd),
    .result (exec_result)
  );

`ifndef NO_ASSERTIONS
  // every accepted transaction raises done once it has passed the input and result registers
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("accepted transaction produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |-> $past(in_valid))
    else $error("result strobe without a transaction in flight");

  // flag operations give a bare 0/1 in the low limb
  a_flag_shape: assert property (@(posedge clk) disable iff (rst)
    (in_valid && is_flag_mode(in_cmd.mode)) |=>
      (result.result_w1 == '0) && (result.result_w2 == '0) &&
      (result.result_w3 == '0) && (result.result_w0[LimbBits-1:1] == '0))
    else $error("flag result wider than one bit");
`endif

endmodule

FILE: design/evm_alu_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evm_alu_exec
// Combinational 256-bit datapath: arithmetic, compare, logic, byte, shifts
// and sign extension for one registered command.
// ----------------------------------------------------------------------------
module evm_alu_exec (
  input  evm_alu_pkg::alu_cmd_t    cmd,
  output evm_alu_pkg::alu_result_t result
);
  import evm_alu_pkg::*;

  logic [WordBits-1:0] a;
  logic [WordBits-1:0] b;
  logic [WordBits-1:0] r;

  logic                a_high_zero;  // a[255:5] clear: small byte index
  logic                shift_big;    // shift of 256 or more
  logic [7:0]          shift_n;
  logic [7:0]          sar_n;
  logic [7:0]          byte_pos;
  logic [7:0]          byte_val;
  logic [WordBits-1:0] shl_val;
  logic [WordBits-1:0] shr_val;
  logic [WordBits-1:0] sar_val;
  logic [7:0]          sext_bit;
  logic                sext_sign;
  logic [WordBits-1:0] sext_keep;
  logic [WordBits-1:0] sext_val;
  logic                sext_on;

  assign a = {cmd.first_w3, cmd.first_w2, cmd.first_w1, cmd.first_w0};
  assign b = {cmd.second_w3, cmd.second_w2, cmd.second_w1, cmd.second_w0};

  assign a_high_zero = ~|a[WordBits-1:5];
  assign shift_big   = |a[WordBits-1:8];
  assign shift_n     = a[7:0];

  // byte counted from the msb: bit position (31 - idx) * 8
  assign byte_pos = {~a[4:0], 3'b000};
  assign byte_val = 8'(b >> byte_pos);

  assign shl_val = shift_big ? '0 : (b << shift_n);
  assign shr_val = shift_big ? '0 : (b >> shift_n);
  // a shift by 255 already gives pure sign fill
  assign sar_n   = shift_big ? 8'hFF : shift_n;
  assign sar_val = $unsigned($signed(b) >>> sar_n);

  // sign bit sits at idx * 8 + 7; keep everything at or below it
  assign sext_bit  = {a[4:0], 3'b111};
  assign sext_sign = b[sext_bit];
  assign sext_keep = {WordBits{1'b1}} >> (~sext_bit);
  assign sext_on   = a_high_zero && (a[4:0] != 5'd31);
  assign sext_val  = sext_on ? ((b & sext_keep) | ({WordBits{sext_sign}} & ~sext_keep))
                             : b;

  always_comb begin
    unique case (cmd.mode)
      MODE_ADD:        r = a + b;
      MODE_SUB:        r = a - b;
      MODE_LT:         r = {{(WordBits-1){1'b0}}, a < b};
      MODE_GT:         r = {{(WordBits-1){1'b0}}, a > b};
      MODE_SLT:        r = {{(WordBits-1){1'b0}}, $signed(a) < $signed(b)};
      MODE_SGT:        r = {{(WordBits-1){1'b0}}, $signed(a) > $signed(b)};
      MODE_EQ:         r = {{(WordBits-1){1'b0}}, a == b};
      MODE_ISZERO:     r = {{(WordBits-1){1'b0}}, ~|a};
      MODE_AND:        r = a & b;
      MODE_OR:         r = a | b;
      MODE_XOR:        r = a ^ b;
      MODE_NOT:        r = ~a;
      MODE_BYTE:       r = a_high_zero ? {{(WordBits-8){1'b0}}, byte_val} : '0;
      MODE_SHL:        r = shl_val;
      MODE_SHR:        r = shr_val;
      MODE_SAR:        r = sar_val;
      MODE_SIGNEXTEND: r = sext_val;
      default:         r = '0;
    endcase
  end

  assign result.result_w0 = r[LimbBits-1:0];
  assign result.result_w1 = r[2*LimbBits-1:LimbBits];
  assign result.result_w2 = r[3*LimbBits-1:2*LimbBits];
  assign result.result_w3 = r[4*LimbBits-1:3*LimbBits];

endmodule
